// ===== hdl/drc_pkg.sv =====
// drc_pkg: shared types and constants for the directory record checker.
// Holds the record layout, result bundle, status codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package drc_pkg;

	localparam int RECORD_LEN    = 26;
	localparam int LAST_POS      = RECORD_LEN - 1;
	localparam int POS_W         = $clog2(RECORD_LEN);
	localparam int ALIGN_BYTES   = 16384;
	localparam int ALIGN_LOG2    = $clog2(ALIGN_BYTES);
	localparam int REC_COUNT_W   = 20;
	localparam logic [7:0] MAX_PRECISION = 8'd3;

	typedef enum logic {
		REG_DIRECTORY_START = 1'b0,
		REG_RECORD_COUNT    = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_OK            = 3'd0,
		ST_BAD_PRECISION = 3'd1,
		ST_ZERO_LENGTH   = 3'd2,
		ST_MISALIGNED    = 3'd3,
		ST_OUT_OF_BOUNDS = 3'd4,
		ST_OVERFLOW      = 3'd5,
		ST_SKIPPED       = 3'd6
	} status_t;

	// little-endian record, byte 0 in the low bits
	typedef struct packed {
		logic [31:0] payload_crc;
		logic [31:0] payload_length;
		logic [63:0] payload_offset;
		logic [31:0] heat_pattern;
		logic [7:0]  flag_bits;
		logic [7:0]  precision_code;
		logic [15:0] expert_id;
		logic [15:0] layer_id;
	} record_t;

	typedef struct packed {
		record_t     rec;
		status_t     status;
		logic [31:0] largest_length;
		logic [63:0] length_total;
		logic        last_record;
	} result_t;

endpackage

// ===== hdl/drc_assemble.sv =====
// drc_assemble: collects directory bytes into one 26-byte record.
// Presents a complete record in the _s1 register. Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_assemble (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             data_valid,
	output logic             data_stall,
	input  logic [7:0]       data_byte,
	input  logic             advance,
	output logic             valid_s1,
	output drc_pkg::record_t record_s1
);

	logic [drc_pkg::POS_W-1:0]          pos_q;
	logic [drc_pkg::LAST_POS*8-1:0]     shift_q;
	logic                               rec_end;
	logic                               accept;

	assign data_stall = valid_s1 & ~advance;
	assign accept     = data_valid & ~data_stall;
	assign rec_end    = (pos_q == drc_pkg::POS_W'(drc_pkg::LAST_POS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (rec_end) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end
			if (accept && rec_end) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !rec_end) begin
			shift_q <= {data_byte, shift_q[drc_pkg::LAST_POS*8-1:8]};
		end
		if (accept && rec_end) begin
			record_s1 <= drc_pkg::record_t'({data_byte, shift_q});
		end
	end

endmodule

// ===== hdl/drc_check.sv =====
// drc_check: record checks, running length statistics and result register.
// Takes the assembled record from drc_assemble. Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_check (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            valid_s1,
	input  drc_pkg::record_t                record_s1,
	input  logic                            result_stall,
	input  logic [63:0]                     directory_start,
	input  logic [drc_pkg::REC_COUNT_W-1:0] record_count,
	output logic                            advance,
	output logic                            result_valid,
	output drc_pkg::result_t                result_q
);

	logic [drc_pkg::REC_COUNT_W-1:0] seen_q;
	logic [31:0]                     max_q;
	logic [63:0]                     sum_q;
	logic                            err_q;

	drc_pkg::status_t                status;
	logic [63:0]                     room;
	logic [64:0]                     sum_ext;
	logic [31:0]                     max_next;
	logic [63:0]                     sum_next;
	logic                            last;
	logic [drc_pkg::REC_COUNT_W:0]   seen_inc;

	assign advance = valid_s1 & (~result_valid | ~result_stall);

	always_comb begin
		room     = directory_start - record_s1.payload_offset;
		sum_ext  = {1'b0, sum_q} + {33'b0, record_s1.payload_length};
		seen_inc = {1'b0, seen_q} + 1'b1;
		last     = (seen_inc >= {1'b0, record_count});

		if (err_q) begin
			status = drc_pkg::ST_SKIPPED;
		end else if (record_s1.precision_code > drc_pkg::MAX_PRECISION) begin
			status = drc_pkg::ST_BAD_PRECISION;
		end else if (record_s1.payload_length == '0) begin
			status = drc_pkg::ST_ZERO_LENGTH;
		end else if (record_s1.payload_offset[drc_pkg::ALIGN_LOG2-1:0] != '0
				|| record_s1.payload_offset == '0) begin
			status = drc_pkg::ST_MISALIGNED;
		end else if (record_s1.payload_offset > directory_start
				|| {32'b0, record_s1.payload_length} > room) begin
			status = drc_pkg::ST_OUT_OF_BOUNDS;
		end else if (sum_ext[64]) begin
			status = drc_pkg::ST_OVERFLOW;
		end else begin
			status = drc_pkg::ST_OK;
		end

		max_next = max_q;
		sum_next = sum_q;
		if (status == drc_pkg::ST_OK) begin
			sum_next = sum_ext[63:0];
			if (record_s1.payload_length > max_q) begin
				max_next = record_s1.payload_length;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			err_q        <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (advance) begin
				result_valid <= 1'b1;
				if (last) begin
					seen_q <= '0;
					max_q  <= '0;
					sum_q  <= '0;
					err_q  <= 1'b0;
				end else begin
					seen_q <= seen_inc[drc_pkg::REC_COUNT_W-1:0];
					max_q  <= max_next;
					sum_q  <= sum_next;
					if (status != drc_pkg::ST_OK && status != drc_pkg::ST_SKIPPED) begin
						err_q <= 1'b1;
					end
				end
			end else if (!result_stall) begin
				result_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.rec            <= record_s1;
			result_q.status         <= status;
			result_q.largest_length <= max_next;
			result_q.length_total   <= sum_next;
			result_q.last_record    <= last;
		end
	end

endmodule

// ===== hdl/directory_record_checker_top.sv =====
// A record goes through the single record stage (_s1), then the result register.
// Throughput: one byte per cycle while data_stall is low, one result per 26 bytes; a
// result waiting in the output register holds only the record behind it.
// Reset (arst_n, async, active low): byte position, record and error state, running
// statistics and valid flags clear; directory_start = 16384, record_count = 1.
// Depends on drc_pkg, drc_assemble, drc_check.
`timescale 1ns / 1ps

module directory_record_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [15:0] layer_id,
	output logic [15:0] expert_id,
	output logic [7:0]  precision_code,
	output logic [7:0]  flag_bits,
	output logic [31:0] heat_pattern,
	output logic [63:0] payload_offset,
	output logic [31:0] payload_length,
	output logic [31:0] payload_crc,
	output logic [2:0]  status,
	output logic [31:0] largest_length,
	output logic [63:0] length_total,
	output logic        last_record
);

	logic [63:0]                     dir_start_q;
	logic [drc_pkg::REC_COUNT_W-1:0] rec_count_q;
	logic                            advance;
	logic                            valid_s1;
	drc_pkg::record_t                record_s1;
	drc_pkg::result_t                result_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_start_q <= 64'd16384;
			rec_count_q <= drc_pkg::REC_COUNT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (drc_pkg::cfg_reg_t'(cfg_index))
				drc_pkg::REG_DIRECTORY_START: begin
					dir_start_q <= cfg_data;
				end
				drc_pkg::REG_RECORD_COUNT: begin
					rec_count_q <= cfg_data[drc_pkg::REC_COUNT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	drc_assemble u_assemble (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_stall (data_stall),
		.data_byte  (data_byte),
		.advance    (advance),
		.valid_s1   (valid_s1),
		.record_s1  (record_s1)
	);

	drc_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.valid_s1        (valid_s1),
		.record_s1       (record_s1),
		.result_stall    (result_stall),
		.directory_start (dir_start_q),
		.record_count    (rec_count_q),
		.advance         (advance),
		.result_valid    (result_valid),
		.result_q        (result_q)
	);

	assign layer_id       = result_q.rec.layer_id;
	assign expert_id      = result_q.rec.expert_id;
	assign precision_code = result_q.rec.precision_code;
	assign flag_bits      = result_q.rec.flag_bits;
	assign heat_pattern   = result_q.rec.heat_pattern;
	assign payload_offset = result_q.rec.payload_offset;
	assign payload_length = result_q.rec.payload_length;
	assign payload_crc    = result_q.rec.payload_crc;
	assign status         = result_q.status;
	assign largest_length = result_q.largest_length;
	assign length_total   = result_q.length_total;
	assign last_record    = result_q.last_record;

endmodule

// ===== hdl/drc_props.sv =====
// drc_props: port-level checks for directory_record_checker_top, bound to the top.
// Depends on drc_pkg.
`timescale 1ns / 1ps

module drc_props (
	input logic        clk,
	input logic        arst_n,
	input logic        data_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [7:0]  precision_code,
	input logic [63:0] payload_offset,
	input logic [31:0] payload_length,
	input logic [2:0]  status,
	input logic [31:0] largest_length,
	input logic [63:0] length_total
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(payload_length)
			&& $stable(status) && $stable(length_total))
		else $error("result beat changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> result_valid && result_stall)
		else $error("input stalled without a blocked result");

	a_ok_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == drc_pkg::ST_OK |->
			precision_code <= drc_pkg::MAX_PRECISION && payload_length != '0
			&& payload_offset[drc_pkg::ALIGN_LOG2-1:0] == '0 && payload_offset != '0)
		else $error("record passed with a failing field");

	a_ok_stats: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == drc_pkg::ST_OK |->
			largest_length >= payload_length && length_total >= {32'b0, payload_length})
		else $error("running statistics miss an accepted length");

endmodule

bind directory_record_checker_top drc_props u_props (.*);
